@@ hdl/abilp_pkg.sv @@
`default_nettype none

package abilp_pkg;

    // value width; the port stays 64 bits, the accumulator follows this
    localparam int VALUE_BITS = 64;
    // room for the largest shift (times 16) plus a digit
    localparam int WIDE_BITS  = VALUE_BITS + 4;
    localparam int PORT_BITS  = 64;

    // parser phase
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_ZERO   = 2'd1,
        PH_PREFIX = 2'd2,
        PH_DIGITS = 2'd3
    } t_phase;

    // base codes as reported on the result
    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_OCT = 2'd2,
        BASE_BIN = 2'd3
    } t_base;

    // ascii codes
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_1 = 8'h31;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_B  = 8'h42;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    // code for a character that is no hex digit
    localparam logic [4:0] DIGIT_NONE = 5'd16;

    // hex digit value of a character, DIGIT_NONE if it is none
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            d = 5'(c - CH_DIG_0);
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            d = 5'(c - CH_LC_A) + 5'd10;
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            d = 5'(c - CH_UC_A) + 5'd10;
        end else begin
            d = DIGIT_NONE;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hdl/auto_base_integer_literal_parser_unit.sv @@
`default_nettype none

// Integer literal parser with base taken from the prefix (0x hex, 0b binary,
// leading 0 octal, 1-9 decimal). It takes one character per clock, every
// clock while o_in_stall is low, with no gaps between strings; the result
// register is loaded as the character marked last leaves the input register.
// The rate is set by the per-character state update: one multiply-by-base
// (as shifts) and add on the accumulator, done combinationally between the
// input and state registers. Stalling the output holds back the input only
// when a last character is waiting for a full output register.
module auto_base_integer_literal_parser_unit
    import abilp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input requests
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_character,
    input  wire logic                 i_last_char,
    // result requests
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_valid_res,
    output logic [1:0]                o_base_code,
    output logic [PORT_BITS-1:0]      o_value,
    output logic                      o_overflowed
);

    // input register
    logic                  r_s1_valid;
    logic [7:0]            r_s1_char;
    logic                  r_s1_last;

    // parser state
    t_phase                r_phase, n_phase;
    t_base                 r_base, n_base;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_err, n_err;
    logic                  r_wrap, n_wrap;

    // result register
    logic                  r_out_valid;
    logic                  r_out_ok;
    t_base                 r_out_base;
    logic [PORT_BITS-1:0]  r_out_value;
    logic                  r_out_ovf;

    logic                  s1_advance;
    logic                  out_free;
    t_base                 dig_base;
    logic [4:0]            dig_val;
    logic                  dig_ok;
    logic [WIDE_BITS-1:0]  acc_x;
    logic [WIDE_BITS-1:0]  acc_wide;
    logic                  dig_wrap;
    logic                  res_ok;

    // flow control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_advance = r_s1_valid && (!r_s1_last || out_free);
    assign o_in_stall = r_s1_valid && !s1_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_char <= i_character;
            r_s1_last <= i_last_char;
        end
    end

    // digit step: check against base, value*base+digit with wrap detect
    always_comb begin
        dig_base = (r_phase == PH_ZERO) ? BASE_OCT : r_base;
        dig_val  = digit_value(r_s1_char);
        acc_x    = WIDE_BITS'(r_acc);
        case (dig_base)
            BASE_DEC: begin
                dig_ok   = dig_val < 5'd10;
                acc_wide = (acc_x << 3) + (acc_x << 1);
            end
            BASE_HEX: begin
                dig_ok   = dig_val != DIGIT_NONE;
                acc_wide = acc_x << 4;
            end
            BASE_OCT: begin
                dig_ok   = dig_val < 5'd8;
                acc_wide = acc_x << 3;
            end
            BASE_BIN: begin
                dig_ok   = dig_val < 5'd2;
                acc_wide = acc_x << 1;
            end
            default: begin
                dig_ok   = 1'b0;
                acc_wide = acc_x;
            end
        endcase
        acc_wide = acc_wide + WIDE_BITS'(dig_val[3:0]);
        dig_wrap = |acc_wide[WIDE_BITS-1:VALUE_BITS];
    end

    // next state and result
    always_comb begin
        n_phase = r_phase;
        n_base  = r_base;
        n_acc   = r_acc;
        n_err   = r_err;
        n_wrap  = r_wrap;
        if (!r_err) begin
            case (r_phase)
                PH_START: begin
                    if (r_s1_char == CH_DIG_0) begin
                        n_base  = BASE_OCT;
                        n_phase = PH_ZERO;
                    end else if (r_s1_char >= CH_DIG_1 && r_s1_char <= CH_DIG_9) begin
                        n_base  = BASE_DEC;
                        n_acc   = VALUE_BITS'(dig_val[3:0]);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (r_s1_char == CH_LC_X || r_s1_char == CH_UC_X) begin
                        n_base  = BASE_HEX;
                        n_phase = PH_PREFIX;
                    end else if (r_s1_char == CH_LC_B || r_s1_char == CH_UC_B) begin
                        n_base  = BASE_BIN;
                        n_phase = PH_PREFIX;
                    end else begin
                        n_base  = BASE_OCT;
                        n_phase = PH_DIGITS;
                        if (dig_ok) begin
                            n_acc  = acc_wide[VALUE_BITS-1:0];
                            n_wrap = r_wrap || dig_wrap;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_DIGITS;
                    if (dig_ok) begin
                        n_acc  = acc_wide[VALUE_BITS-1:0];
                        n_wrap = r_wrap || dig_wrap;
                    end else begin
                        n_err = 1'b1;
                    end
                end
            endcase
        end
        res_ok = !n_err && n_phase != PH_START && n_phase != PH_PREFIX;
    end

    // parser state registers; a last character returns to start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_base  <= BASE_DEC;
            r_acc   <= '0;
            r_err   <= 1'b0;
            r_wrap  <= 1'b0;
        end else if (s1_advance) begin
            if (r_s1_last) begin
                r_phase <= PH_START;
                r_base  <= BASE_DEC;
                r_acc   <= '0;
                r_err   <= 1'b0;
                r_wrap  <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_base  <= n_base;
                r_acc   <= n_acc;
                r_err   <= n_err;
                r_wrap  <= n_wrap;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_last) begin
            r_out_ok    <= res_ok;
            r_out_base  <= n_base;
            r_out_value <= res_ok ? PORT_BITS'(n_acc) : '0;
            r_out_ovf   <= res_ok && n_wrap;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_valid_res  = r_out_ok;
    assign o_base_code  = r_out_base;
    assign o_value      = r_out_value;
    assign o_overflowed = r_out_ovf;

endmodule

`default_nettype wire

@@ hdl/abilp_chk.sv @@
`default_nettype none

module abilp_chk
    import abilp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 o_in_stall,
    input  wire logic [7:0]           i_character,
    input  wire logic                 i_last_char,
    input  wire logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic                 o_valid_res,
    input  wire logic [1:0]           o_base_code,
    input  wire logic [PORT_BITS-1:0] o_value,
    input  wire logic                 o_overflowed
);

    // a stalled result request stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    // a stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_valid_res) && $stable(o_base_code) &&
            $stable(o_value) && $stable(o_overflowed))
        else $error("stalled result changed");

    // an invalid literal reports zero value and no wrap
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |-> o_value == '0 && !o_overflowed)
        else $error("invalid literal with nonzero value or wrap");

    // wrap is only reported on a legal literal
    a_wrap_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflowed |-> o_valid_res)
        else $error("wrap reported on an invalid literal");

endmodule

bind auto_base_integer_literal_parser_unit abilp_chk u_abilp_chk (.*);

`default_nettype wire
